// ----- src/utrsf_pkg.sv -----
// Shared widths, constants and pipeline payload types for the ramp slope fit.
package utrsf_pkg;

   localparam int PIX_W    = 12;
   localparam int READ_W   = 6;
   localparam int TIME_W   = 24;
   localparam int SAMPLE_W = 16;
   localparam int NREAD_W  = 7;
   localparam int MAX_READS = 64;

   localparam int STS_W = 52;
   localparam int SS_W  = 22;
   localparam int ST_W  = 30;
   localparam int STT_W = 54;

   localparam int TS_W   = TIME_W + SAMPLE_W;
   localparam int TT_W   = 2 * TIME_W;
   localparam int NUM_W  = 61;
   localparam int DEN_W  = 62;
   localparam int DUR_W  = TIME_W + 1;
   localparam int AMAG_W = 60;
   localparam int DMAG_W = 61;
   localparam int FRAC_W = 8;
   localparam int M_W    = TIME_W + FRAC_W;
   localparam int HALF_W = 32;
   localparam int PROD_W = AMAG_W + M_W;
   localparam int SIG_W  = 32;

   typedef struct packed {
      logic [STS_W-1:0]  sts;
      logic [SS_W-1:0]   ss;
      logic [ST_W-1:0]   st;
      logic [STT_W-1:0]  stt;
      logic [TIME_W-1:0] first;
   } sums_type;

   typedef struct packed {
      logic               valid;
      logic [PIX_W-1:0]   pixel;
      logic [TIME_W-1:0]  rtime;
      logic [NREAD_W-1:0] n;
      sums_type           sums;
   } acc_type;

   typedef struct packed {
      logic              valid;
      logic [PIX_W-1:0]  pixel;
      logic [PROD_W-1:0] prod;
      logic [DMAG_W-1:0] dmag;
      logic              neg;
      logic              degenerate;
   } fit_type;

   typedef struct packed {
      logic              valid;
      logic [PIX_W-1:0]  pixel;
      logic [DMAG_W-1:0] rem;
      logic [DMAG_W-1:0] dmag;
      logic [HALF_W-1:0] lo;
      logic [SIG_W-1:0]  quo;
      logic              ovf;
      logic              neg;
      logic              degenerate;
   } div_type;

   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] pixel;
      logic [SIG_W-1:0] signal;
      logic             degenerate;
   } result_type;

endpackage

// ----- src/utrsf_accum.sv -----
// Per-pixel sum memory with read-modify-write and forwarding of the latest update.
module utrsf_accum #(
   parameter int NUM_PIXELS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [utrsf_pkg::PIX_W-1:0]     in_pixel,
   input  logic [utrsf_pkg::READ_W-1:0]    in_read,
   input  logic [utrsf_pkg::TIME_W-1:0]    in_time,
   input  logic [utrsf_pkg::SAMPLE_W-1:0]  in_sample,
   input  logic [utrsf_pkg::NREAD_W-1:0]   num_reads,
   output utrsf_pkg::acc_type              acc_out
);

   localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

   utrsf_pkg::sums_type mem [NUM_PIXELS];
   utrsf_pkg::sums_type rd_data_ff;

   logic                             s0_valid_ff;
   logic [utrsf_pkg::PIX_W-1:0]      s0_pixel_ff;
   logic [utrsf_pkg::READ_W-1:0]     s0_read_ff;
   logic [utrsf_pkg::TIME_W-1:0]     s0_time_ff;
   logic [utrsf_pkg::SAMPLE_W-1:0]   s0_sample_ff;
   logic [utrsf_pkg::TS_W-1:0]       s0_ts_ff;
   logic [utrsf_pkg::TT_W-1:0]       s0_tt_ff;

   logic                             s1_valid_ff;
   logic                             s1_emit_ff;
   logic [utrsf_pkg::PIX_W-1:0]      s1_pixel_ff;
   logic [utrsf_pkg::TIME_W-1:0]     s1_time_ff;
   logic [utrsf_pkg::NREAD_W-1:0]    s1_n_ff;
   utrsf_pkg::sums_type              s1_sums_ff;

   logic                             in_range;
   logic [AW-1:0]                    in_addr;
   logic [AW-1:0]                    s0_addr;
   utrsf_pkg::sums_type              base;
   utrsf_pkg::sums_type              sums_in;
   logic                             emit_in;

   assign in_range = 32'(in_pixel) < NUM_PIXELS;
   assign in_addr  = AW'(in_pixel);
   assign s0_addr  = AW'(s0_pixel_ff);

   always_comb begin
      if (s1_valid_ff && (s1_pixel_ff == s0_pixel_ff)) begin
         base = s1_sums_ff;
      end else begin
         base = rd_data_ff;
      end
      if (s0_read_ff == '0) begin
         base = '0;
         base.first = s0_time_ff;
      end
      sums_in.sts   = base.sts + utrsf_pkg::STS_W'(s0_ts_ff);
      sums_in.ss    = base.ss + utrsf_pkg::SS_W'(s0_sample_ff);
      sums_in.st    = base.st + utrsf_pkg::ST_W'(s0_time_ff);
      sums_in.stt   = base.stt + utrsf_pkg::STT_W'(s0_tt_ff);
      sums_in.first = base.first;
      emit_in = (utrsf_pkg::NREAD_W'(s0_read_ff) + 1'b1 == num_reads)
                && (num_reads <= utrsf_pkg::NREAD_W'(utrsf_pkg::MAX_READS));
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid && in_range) begin
         rd_data_ff <= mem[in_addr];
      end
      if (advance && s0_valid_ff) begin
         mem[s0_addr] <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= in_valid && in_range;
         s1_valid_ff <= s0_valid_ff;
         s1_emit_ff  <= s0_valid_ff && emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_pixel_ff  <= in_pixel;
         s0_read_ff   <= in_read;
         s0_time_ff   <= in_time;
         s0_sample_ff <= in_sample;
         s0_ts_ff     <= in_time * in_sample;
         s0_tt_ff     <= in_time * in_time;
         s1_pixel_ff  <= s0_pixel_ff;
         s1_time_ff   <= s0_time_ff;
         s1_n_ff      <= num_reads;
         s1_sums_ff   <= sums_in;
      end
   end

   always_comb begin
      acc_out.valid = s1_emit_ff;
      acc_out.pixel = s1_pixel_ff;
      acc_out.rtime = s1_time_ff;
      acc_out.n     = s1_n_ff;
      acc_out.sums  = s1_sums_ff;
   end

endmodule

// ----- src/utrsf_fit.sv -----
// Fit numerator, denominator and duration, scaled product of numerator and duration.
module utrsf_fit (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  utrsf_pkg::acc_type acc_in,
   output utrsf_pkg::fit_type fit_out
);

   localparam int NSTS_W = utrsf_pkg::NREAD_W + utrsf_pkg::STS_W;
   localparam int STSS_W = utrsf_pkg::ST_W + utrsf_pkg::SS_W;
   localparam int NSTT_W = utrsf_pkg::NREAD_W + utrsf_pkg::STT_W;
   localparam int STST_W = 2 * utrsf_pkg::ST_W;
   localparam int HI_W   = utrsf_pkg::AMAG_W - utrsf_pkg::HALF_W;
   localparam int PPL_W  = utrsf_pkg::HALF_W + utrsf_pkg::M_W;
   localparam int PPH_W  = HI_W + utrsf_pkg::M_W;

   logic [4:0]                      valid_ff;
   logic [utrsf_pkg::PIX_W-1:0]     pix1_ff, pix2_ff, pix3_ff, pix4_ff, pix5_ff;

   logic [NSTS_W-1:0]               nsts_ff;
   logic [STSS_W-1:0]               stss_ff;
   logic [NSTT_W-1:0]               nstt_ff;
   logic [STST_W-1:0]               stst_ff;
   logic signed [utrsf_pkg::DUR_W-1:0] dur1_ff, dur2_ff;

   logic signed [utrsf_pkg::NUM_W-1:0] num_ff;
   logic signed [utrsf_pkg::DEN_W-1:0] den_ff;

   logic [utrsf_pkg::AMAG_W-1:0]    amag_ff;
   logic [utrsf_pkg::DMAG_W-1:0]    dmag3_ff, dmag4_ff, dmag5_ff;
   logic [utrsf_pkg::M_W-1:0]       m_ff;
   logic                            neg3_ff, neg4_ff, neg5_ff;
   logic                            deg3_ff, deg4_ff, deg5_ff;

   logic [PPL_W-1:0]                ppl_ff;
   logic [PPH_W-1:0]                pph_ff;
   logic [utrsf_pkg::PROD_W-1:0]    prod_ff;

   logic signed [utrsf_pkg::NUM_W-1:0] num_in;
   logic signed [utrsf_pkg::DEN_W-1:0] den_in;
   logic signed [utrsf_pkg::DUR_W-1:0] dur_in;
   logic [utrsf_pkg::NUM_W-1:0]        anum;
   logic [utrsf_pkg::DEN_W-1:0]        aden;
   logic [utrsf_pkg::DUR_W-1:0]        adur;

   assign dur_in = signed'({1'b0, acc_in.rtime}) - signed'({1'b0, acc_in.sums.first});
   assign num_in = signed'(utrsf_pkg::NUM_W'(nsts_ff) - utrsf_pkg::NUM_W'(stss_ff));
   assign den_in = signed'(utrsf_pkg::DEN_W'(nstt_ff) - utrsf_pkg::DEN_W'(stst_ff));
   assign anum   = num_ff[utrsf_pkg::NUM_W-1] ? -num_ff : num_ff;
   assign aden   = den_ff[utrsf_pkg::DEN_W-1] ? -den_ff : den_ff;
   assign adur   = dur2_ff[utrsf_pkg::DUR_W-1] ? -dur2_ff : dur2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], acc_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix1_ff <= acc_in.pixel;
         nsts_ff <= acc_in.n * acc_in.sums.sts;
         stss_ff <= acc_in.sums.st * acc_in.sums.ss;
         nstt_ff <= acc_in.n * acc_in.sums.stt;
         stst_ff <= acc_in.sums.st * acc_in.sums.st;
         dur1_ff <= dur_in;

         pix2_ff <= pix1_ff;
         num_ff  <= num_in;
         den_ff  <= den_in;
         dur2_ff <= dur1_ff;

         pix3_ff  <= pix2_ff;
         amag_ff  <= utrsf_pkg::AMAG_W'(anum);
         dmag3_ff <= utrsf_pkg::DMAG_W'(aden);
         m_ff     <= {adur[utrsf_pkg::TIME_W-1:0], utrsf_pkg::FRAC_W'(0)};
         neg3_ff  <= (num_ff[utrsf_pkg::NUM_W-1] ^ dur2_ff[utrsf_pkg::DUR_W-1])
                     ^ den_ff[utrsf_pkg::DEN_W-1];
         deg3_ff  <= (den_ff == '0);

         pix4_ff  <= pix3_ff;
         ppl_ff   <= amag_ff[utrsf_pkg::HALF_W-1:0] * m_ff;
         pph_ff   <= amag_ff[utrsf_pkg::AMAG_W-1:utrsf_pkg::HALF_W] * m_ff;
         dmag4_ff <= dmag3_ff;
         neg4_ff  <= neg3_ff;
         deg4_ff  <= deg3_ff;

         pix5_ff  <= pix4_ff;
         prod_ff  <= utrsf_pkg::PROD_W'(ppl_ff)
                     + (utrsf_pkg::PROD_W'(pph_ff) << utrsf_pkg::HALF_W);
         dmag5_ff <= dmag4_ff;
         neg5_ff  <= neg4_ff;
         deg5_ff  <= deg4_ff;
      end
   end

   always_comb begin
      fit_out.valid      = valid_ff[4];
      fit_out.pixel      = pix5_ff;
      fit_out.prod       = prod_ff;
      fit_out.dmag       = dmag5_ff;
      fit_out.neg        = neg5_ff;
      fit_out.degenerate = deg5_ff;
   end

endmodule

// ----- src/utrsf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
module utrsf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  utrsf_pkg::fit_type    fit_in,
   output utrsf_pkg::result_type res_out
);

   localparam int STEPS = utrsf_pkg::HALF_W;
   localparam int HI_W  = utrsf_pkg::PROD_W - utrsf_pkg::HALF_W;
   localparam int RS_W  = utrsf_pkg::DMAG_W + 1;

   utrsf_pkg::div_type stage_ff [STEPS+1];
   utrsf_pkg::div_type stage_in [STEPS+1];

   logic [HI_W-1:0] hi;
   assign hi = fit_in.prod[utrsf_pkg::PROD_W-1:utrsf_pkg::HALF_W];

   always_comb begin
      stage_in[0].valid      = fit_in.valid;
      stage_in[0].pixel      = fit_in.pixel;
      stage_in[0].rem        = utrsf_pkg::DMAG_W'(hi);
      stage_in[0].dmag       = fit_in.dmag;
      stage_in[0].lo         = fit_in.prod[utrsf_pkg::HALF_W-1:0];
      stage_in[0].quo        = '0;
      stage_in[0].ovf        = utrsf_pkg::DMAG_W'(hi) >= fit_in.dmag;
      stage_in[0].neg        = fit_in.neg;
      stage_in[0].degenerate = fit_in.degenerate;
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [RS_W-1:0] rs;
      logic            ge;
      assign rs = {stage_ff[j].rem, stage_ff[j].lo[utrsf_pkg::HALF_W-1]};
      assign ge = rs >= {1'b0, stage_ff[j].dmag};
      always_comb begin
         stage_in[j+1]     = stage_ff[j];
         stage_in[j+1].rem = ge ? utrsf_pkg::DMAG_W'(rs - {1'b0, stage_ff[j].dmag})
                                : utrsf_pkg::DMAG_W'(rs);
         stage_in[j+1].lo  = {stage_ff[j].lo[utrsf_pkg::HALF_W-2:0], 1'b0};
         stage_in[j+1].quo = {stage_ff[j].quo[utrsf_pkg::SIG_W-2:0], ge};
      end
   end

   for (genvar k = 0; k <= STEPS; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (advance) begin
            stage_ff[k].valid <= stage_in[k].valid;
         end
         if (advance) begin
            stage_ff[k].pixel      <= stage_in[k].pixel;
            stage_ff[k].rem        <= stage_in[k].rem;
            stage_ff[k].dmag       <= stage_in[k].dmag;
            stage_ff[k].lo         <= stage_in[k].lo;
            stage_ff[k].quo        <= stage_in[k].quo;
            stage_ff[k].ovf        <= stage_in[k].ovf;
            stage_ff[k].neg        <= stage_in[k].neg;
            stage_ff[k].degenerate <= stage_in[k].degenerate;
         end
      end
   end

   localparam logic [utrsf_pkg::SIG_W-1:0] POS_MAX = {1'b0, {(utrsf_pkg::SIG_W-1){1'b1}}};
   localparam logic [utrsf_pkg::SIG_W-1:0] NEG_MAG = {1'b1, {(utrsf_pkg::SIG_W-1){1'b0}}};

   logic [utrsf_pkg::SIG_W-1:0] qsat;
   logic [utrsf_pkg::SIG_W-1:0] mag;

   always_comb begin
      qsat = stage_ff[STEPS].ovf ? '1 : stage_ff[STEPS].quo;
      res_out.valid      = stage_ff[STEPS].valid;
      res_out.pixel      = stage_ff[STEPS].pixel;
      res_out.degenerate = stage_ff[STEPS].degenerate;
      if (stage_ff[STEPS].neg) begin
         mag = (qsat > NEG_MAG) ? NEG_MAG : qsat;
         res_out.signal = -mag;
      end else begin
         mag = (qsat > POS_MAX) ? POS_MAX : qsat;
         res_out.signal = mag;
      end
      if (stage_ff[STEPS].degenerate) begin
         res_out.signal = '0;
      end
   end

endmodule

// ----- src/up_the_ramp_slope_fit.sv -----
// Top level of the up-the-ramp least-squares slope fit with its output skid buffer.
//
// Each req transfer carries one sample of one pixel at one read of its ramp. Read 0
// restarts that pixel's sums and records its first time stamp; the read whose number
// is num_reads-1 produces one rsp transfer with the pixel, the slope times the ramp
// duration in signed fixed point with 8 fraction bits, and tuser set when the fit is
// degenerate (signal forced to zero). Pixels at or above NUM_PIXELS are dropped.
// The csr channel sets num_reads (reset value 2) and is always ready; write it only
// while no ramp is in flight. A pixel's sums are undefined until its read 0 arrives.
// One item is accepted per clock while req_tready is high. Each sample passes in order
// through the sum memory read-modify-write, the fit arithmetic, the bit-per-stage
// divider and the output register.
// A stalled receiver fills the output register and then the skid register, after
// which req_tready drops until the skid register drains.
// Reset clears all valid bits and the csr register; the sum memory is not cleared.
module up_the_ramp_slope_fit #(
   parameter int NUM_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // pixel_index, read_index, read_time, sample, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_pixel, ramp_signal, zero fill
   output logic [0:0]  rsp_tuser   // degenerate
);

   logic [utrsf_pkg::NREAD_W-1:0] num_reads_ff;
   logic                          advance;
   utrsf_pkg::acc_type            acc;
   utrsf_pkg::fit_type            fit;
   utrsf_pkg::result_type         res;
   utrsf_pkg::result_type         out_ff;
   utrsf_pkg::result_type         skid_ff;
   logic                          out_valid_ff;
   logic                          skid_valid_ff;

   assign csr_ready  = 1'b1;
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_reads_ff <= utrsf_pkg::NREAD_W'(2);
      end else if (csr_valid) begin
         num_reads_ff <= csr_wdata;
      end
   end

   utrsf_accum #(
      .NUM_PIXELS(NUM_PIXELS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_pixel  (req_tdata[11:0]),
      .in_read   (req_tdata[17:12]),
      .in_time   (req_tdata[41:18]),
      .in_sample (req_tdata[57:42]),
      .num_reads (num_reads_ff),
      .acc_out   (acc)
   );

   utrsf_fit u_fit (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .acc_in  (acc),
      .fit_out (fit)
   );

   utrsf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .fit_in  (fit),
      .res_out (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_tready || !out_valid_ff) begin
         out_valid_ff  <= skid_valid_ff || res.valid;
         skid_valid_ff <= 1'b0;
      end else if (res.valid && advance) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (res.valid && advance) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_ff.signal, out_ff.pixel};
   assign rsp_tuser  = out_ff.degenerate;

endmodule

// ----- test/tb_up_the_ramp_slope_fit.sv -----
// Testbench for the ramp slope fit: random ramps checked against an independent predictor.
module tb_up_the_ramp_slope_fit;

   typedef struct {
      logic [utrsf_pkg::PIX_W-1:0] pixel;
      logic [utrsf_pkg::SIG_W-1:0] signal;
      logic                        degenerate;
   } fit_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   logic [63:0]     sample_queue[$];
   fit_result_type  pending_fits[$];
   int              mismatches = 0;
   int              send_gap = 0;
   int              recv_gap = 0;
   int              items_made = 0;
   logic [6:0]      fit_length = 7'd2;

   logic [utrsf_pkg::STS_W-1:0]  time_sample_acc[4096];
   logic [utrsf_pkg::SS_W-1:0]   sample_acc[4096];
   logic [utrsf_pkg::ST_W-1:0]   time_acc[4096];
   logic [utrsf_pkg::STT_W-1:0]  time_sq_acc[4096];
   logic [utrsf_pkg::TIME_W-1:0] start_time[4096];
   bit                           pixel_started[4096];

   up_the_ramp_slope_fit dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 65) return 0;
      if (roll < 95) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 60));
   endfunction

   // Fixed-point slope times duration, truncated toward zero and saturated.
   function automatic logic [utrsf_pkg::SIG_W-1:0] slope_signal(logic signed [63:0] num,
                                                                logic signed [63:0] dur,
                                                                logic signed [63:0] den);
      logic [127:0] prod;
      logic [127:0] quo;
      logic [63:0]  amag;
      logic [63:0]  dmag;
      logic [63:0]  nmag;
      logic         neg;
      if (num == 0 || dur == 0) return '0;
      neg  = ((num < 0) != (dur < 0)) != (den < 0);
      amag = num < 0 ? -num : num;
      dmag = dur < 0 ? -dur : dur;
      nmag = den < 0 ? -den : den;
      prod = 128'(amag) * (128'(dmag) << utrsf_pkg::FRAC_W);
      quo  = prod / 128'(nmag);
      if (neg) begin
         if (quo > 128'h8000_0000) quo = 128'h8000_0000;
         return utrsf_pkg::SIG_W'(-quo);
      end
      if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
      return utrsf_pkg::SIG_W'(quo);
   endfunction

   // Updates one pixel's sums and queues the fit that the block must report.
   function automatic void accumulate_read(logic [utrsf_pkg::PIX_W-1:0] pix,
                                           logic [utrsf_pkg::READ_W-1:0] rd,
                                           logic [utrsf_pkg::TIME_W-1:0] t,
                                           logic [utrsf_pkg::SAMPLE_W-1:0] s);
      logic signed [63:0] num;
      logic signed [63:0] den;
      logic signed [63:0] dur;
      fit_result_type     fit;
      if (rd == 0) begin
         time_sample_acc[pix] = '0;
         sample_acc[pix] = '0;
         time_acc[pix] = '0;
         time_sq_acc[pix] = '0;
         start_time[pix] = t;
      end
      time_sample_acc[pix] += utrsf_pkg::STS_W'(64'(t) * 64'(s));
      sample_acc[pix] += utrsf_pkg::SS_W'(s);
      time_acc[pix] += utrsf_pkg::ST_W'(t);
      time_sq_acc[pix] += utrsf_pkg::STT_W'(64'(t) * 64'(t));
      if (fit_length == 0 || fit_length > utrsf_pkg::MAX_READS
          || 7'(rd) != fit_length - 7'd1) return;
      num = 64'(fit_length) * 64'(time_sample_acc[pix])
            - 64'(time_acc[pix]) * 64'(sample_acc[pix]);
      den = 64'(fit_length) * 64'(time_sq_acc[pix])
            - 64'(time_acc[pix]) * 64'(time_acc[pix]);
      dur = 64'(t) - 64'(start_time[pix]);
      fit.pixel = pix;
      fit.degenerate = (den == 0);
      fit.signal = fit.degenerate ? '0 : slope_signal(num, dur, den);
      pending_fits.push_back(fit);
   endfunction

   task automatic queue_read(logic [utrsf_pkg::PIX_W-1:0] pix,
                             logic [utrsf_pkg::READ_W-1:0] rd,
                             logic [utrsf_pkg::TIME_W-1:0] t,
                             logic [utrsf_pkg::SAMPLE_W-1:0] s);
      if (rd != 0 && !pixel_started[pix]) rd = '0;
      if (rd == 0) pixel_started[pix] = 1'b1;
      accumulate_read(pix, rd, t, s);
      sample_queue.push_back({6'b0, s, t, rd, pix});
      items_made++;
   endtask

   // Several pixels read together, sharing time stamps, with linear signals plus noise.
   task automatic queue_ramps(int n_reads, int n_pix);
      logic [utrsf_pkg::PIX_W-1:0]  pix[8];
      logic [utrsf_pkg::TIME_W-1:0] t;
      int                           step;
      int                           base[8];
      int                           rate[8];
      int                           noise;
      int                           roll;
      roll = int'($urandom_range(0, 9));
      if (roll == 0) step = 0;
      else if (roll == 1) step = int'($urandom_range(0, 16777215));
      else step = int'($urandom_range(1, 5000));
      t = utrsf_pkg::TIME_W'($urandom);
      noise = $urandom_range(0, 3) == 0 ? 2000 : 20;
      for (int k = 0; k < n_pix; k++) begin
         pix[k] = utrsf_pkg::PIX_W'($urandom);
         base[k] = int'($urandom_range(0, 65535));
         rate[k] = int'($urandom_range(0, 4000)) - 2000;
      end
      for (int i = 0; i < n_reads; i++) begin
         for (int k = 0; k < n_pix; k++)
            queue_read(pix[k], utrsf_pkg::READ_W'(i), t,
                       utrsf_pkg::SAMPLE_W'(base[k] + rate[k] * i
                                            + int'($urandom_range(0, noise))));
         t += utrsf_pkg::TIME_W'(step);
      end
   endtask

   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_tvalid || pending_fits.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_fit_length(logic [6:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      fit_length = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            req_tdata <= sample_queue.pop_front();
            req_tvalid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      fit_result_type fit;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap <= pick_gap();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_fits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected transfer: pixel %0d signal %h degenerate %b",
                           rsp_tdata[11:0], rsp_tdata[43:12], rsp_tuser[0]);
            end else begin
               fit = pending_fits.pop_front();
               if (rsp_tdata[11:0] !== fit.pixel || rsp_tdata[43:12] !== fit.signal
                   || rsp_tuser[0] !== fit.degenerate) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected pixel %0d signal %h degenerate %b, %s %0d %h %b",
                              fit.pixel, fit.signal, fit.degenerate, "got",
                              rsp_tdata[11:0], rsp_tdata[43:12], rsp_tuser[0]);
               end
            end
         end
      end
   end

   initial begin
      int choice;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Extremes of time and sample, then an equal-time ramp, a falling time and repeats.
      queue_read(12'd0, 6'd0, 24'd0, 16'd0);
      queue_read(12'd0, 6'd1, 24'hFFFFFF, 16'hFFFF);
      queue_read(12'd4095, 6'd0, 24'hFFFFFF, 16'hFFFF);
      queue_read(12'd4095, 6'd1, 24'hFFFFFF, 16'h0000);
      queue_read(12'd1, 6'd0, 24'hFFFFFF, 16'h0000);
      queue_read(12'd1, 6'd1, 24'd0, 16'hFFFF);
      queue_read(12'd2, 6'd0, 24'd100, 16'd500);
      queue_read(12'd2, 6'd0, 24'd200, 16'd900);
      queue_read(12'd2, 6'd63, 24'd250, 16'd950);
      queue_read(12'd2, 6'd1, 24'd300, 16'd1300);
      queue_read(12'h555, 6'd0, 24'h555555, 16'h5555);
      queue_read(12'hAAA, 6'd0, 24'hAAAAAA, 16'hAAAA);
      queue_read(12'hAAA, 6'd1, 24'hAAAAAB, 16'h5555);
      queue_read(12'h555, 6'd1, 24'h000001, 16'hAAAA);
      write_fit_length(7'd1);
      queue_read(12'd7, 6'd0, 24'd1234, 16'd4321);
      queue_read(12'd7, 6'd0, 24'hFFFFFF, 16'hFFFF);
      write_fit_length(7'd64);
      queue_ramps(64, 2);
      write_fit_length(7'd0);
      queue_ramps(3, 3);
      write_fit_length(7'd127);
      queue_ramps(4, 2);
      write_fit_length(7'd65);
      queue_ramps(3, 2);
      write_fit_length(7'd2);
      queue_ramps(2, 4);
      while (items_made < 650) begin
         choice = int'($urandom_range(0, 19));
         if (choice == 0) write_fit_length(7'd64);
         else if (choice == 1) write_fit_length(7'(65 + $urandom_range(0, 62)));
         else write_fit_length(7'($urandom_range(1, 8)));
         for (int g = 0; g < 4 && items_made < 650; g++) begin
            if (fit_length >= 1 && fit_length <= utrsf_pkg::MAX_READS && fit_length != 64)
               queue_ramps(int'(fit_length), int'($urandom_range(1, 6)));
            else
               queue_ramps(int'($urandom_range(2, 5)), 2);
            if ($urandom_range(0, 3) == 0)
               queue_read(utrsf_pkg::PIX_W'($urandom), utrsf_pkg::READ_W'($urandom),
                          utrsf_pkg::TIME_W'($urandom), utrsf_pkg::SAMPLE_W'($urandom));
            if (fit_length == 64) break;
         end
      end
      while (sample_queue.size() != 0 || req_tvalid || pending_fits.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (pending_fits.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
